// ===== sv/vob_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel octree builder package
// Command, result kind and register codes, and the fixed field widths.
// ----------------------------------------------------------------------------
package vob_pkg;

   localparam int CMD_W   = 2;
   localparam int POS_W   = 4;
   localparam int COLOR_W = 32;
   localparam int KIND_W  = 2;
   localparam int VALUE_W = 32;
   localparam int MASK_W  = 8;
   localparam int DEPTH_W = 3;
   localparam int CSR_AW  = 1;
   localparam int CSR_DW  = 3;
   localparam int REQ_DW  = 48;
   localparam int RSP_DW  = 40;

   localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BUILD = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEAF   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PARENT = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_EXTENT      = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_ZERO_ABSENT = 1'd1;

   localparam logic [DEPTH_W-1:0] EXTENT_RESET = 3'd4;
   localparam logic [MASK_W-1:0]  MASK_FULL    = 8'hff;

endpackage

// ===== sv/voxel_octree_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel octree builder
// Loads a voxel grid, reduces it level by level into a level store, then
// walks the tree depth first and writes the node list for read-out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           content
//  req      in         tvalid/tready       tuser command, tdata voxel sample
//  rsp      out        tvalid/tready       tuser kind, tdata value and mask
//  csr      in         we                  extent_log2, zero_absent
//
//  Begin sweeps all 2^(3*GRID_LOG2) entries of the voxel RAM, and the same
//  sweep runs after reset. Build reduces each 2x2x2 group on every level
//  with one voxel or level RAM read per child, then walks the tree node by
//  node. The block holds one transaction at a time; req_tready waits for a
//  free result register.
// ----------------------------------------------------------------------------
module voxel_octree_builder #(
   parameter int GRID_LOG2  = 4,
   parameter int COLOR_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [vob_pkg::CMD_W-1:0]     req_tuser,  // command
   input  logic [vob_pkg::REQ_DW-1:0]    req_tdata,  // pos_x, pos_y, pos_z, color, present
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [vob_pkg::KIND_W-1:0]    rsp_tuser,  // result_kind
   output logic [vob_pkg::RSP_DW-1:0]    rsp_tdata,  // value, child_leaf_mask
   output logic                          rsp_tlast,  // last_node
   input  logic                          csr_we,
   input  logic [vob_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [vob_pkg::CSR_DW-1:0]    csr_wdata
);
   import vob_pkg::*;

   localparam int G          = GRID_LOG2;
   localparam int VOX_DEPTH  = 1 << (3 * G);
   localparam int VOX_AW     = G > 0 ? 3 * G : 1;
   localparam int LVL_DEPTH  = (VOX_DEPTH - 1) / 7 + 1;
   localparam int LVL_AW     = LVL_DEPTH > 1 ? $clog2(LVL_DEPTH) : 1;
   localparam int NODE_DEPTH = (VOX_DEPTH * 8 - 1) / 7;
   localparam int NODE_AW    = NODE_DEPTH > 1 ? $clog2(NODE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(NODE_DEPTH + 1);
   localparam int NVAL_W     = COLOR_BITS > CNT_W ? COLOR_BITS : CNT_W;
   localparam int ENT_W      = 1 + NVAL_W + MASK_W;
   localparam int MAXL       = G > 0 ? G : 1;
   localparam int LI_W       = MAXL > 1 ? $clog2(MAXL) : 1;
   localparam int CW         = G > 0 ? G : 1;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_REDUCE = 3'd3;
   localparam logic [2:0] ST_VISIT  = 3'd4;
   localparam logic [2:0] ST_STORE  = 3'd5;
   localparam logic [2:0] ST_NEXT   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [VOX_AW-1:0]     clr_ff, clr_in;
   logic [DEPTH_W-1:0]    extent_ff, extent_in;
   logic                  zabs_ff, zabs_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]      rdidx_ff, rdidx_in;
   logic [DEPTH_W-1:0]    lvl_ff, lvl_in;
   logic [VOX_AW-1:0]     gi_ff, gi_in;
   logic [3:0]            cc_ff, cc_in;
   logic                  k0_leaf_ff, k0_leaf_in;
   logic [NVAL_W-1:0]     k0_col_ff, k0_col_in;
   logic                  uni_ff, uni_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic [LVL_AW-1:0]     base_ff [MAXL];
   logic [LVL_AW-1:0]     base_in [MAXL];
   logic [DEPTH_W-1:0]    wd_ff, wd_in;
   logic [NODE_AW-1:0]    slot_ff, slot_in;
   logic [2:0]            stk_c_ff [MAXL];
   logic [2:0]            stk_c_in [MAXL];
   logic [NODE_AW-1:0]    stk_f_ff [MAXL];
   logic [NODE_AW-1:0]    stk_f_in [MAXL];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [VALUE_W-1:0]    rsp_val_ff, rsp_val_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic [CMD_W-1:0]      cmd;
   logic [POS_W-1:0]      px, py, pz;
   logic [COLOR_W-1:0]    color;
   logic                  present;
   logic [DEPTH_W-1:0]    cur_depth;
   logic [6:0]            side;
   logic                  in_cube;
   logic [CW-1:0]         wx_pos, wy_pos, wz_pos;
   logic [VOX_AW-1:0]     wr_idx;

   logic                  vox_we;
   logic [VOX_AW-1:0]     vox_waddr, vox_raddr;
   logic [COLOR_BITS-1:0] vox_wdata, vox_rdata;
   logic                  lvl_we;
   logic [LVL_AW-1:0]     lvl_waddr, lvl_raddr;
   logic [ENT_W-1:0]      lvl_wdata, lvl_rdata;
   logic                  node_we;
   logic [NODE_AW-1:0]    node_raddr;
   logic [ENT_W-1:0]      node_wdata, node_rdata;

   // Reduction address generation and child accumulation.
   logic [DEPTH_W-1:0]    rk;
   logic [VOX_AW-1:0]     kmask, gx, gy, gz, cx, cy, cz;
   logic [2:0]            cidx, kc;
   logic [VOX_AW-1:0]     vaddr_red, lidx_red, sz, last_gi;
   logic [DEPTH_W-1:0]    lvl_m1;
   logic [LVL_AW-1:0]     laddr_red, waddr_red, base_next;
   logic                  kid_leaf;
   logic [NVAL_W-1:0]     kid_col;
   logic                  uni_n;
   logic [MASK_W-1:0]     mask_n;

   // Walk address generation.
   logic [CW-1:0]         ax, ay, az;
   logic [VOX_AW-1:0]     vaddr_walk, lidx_walk;
   logic [DEPTH_W-1:0]    wl;
   logic [LVL_AW-1:0]     laddr_walk;
   logic                  bottom;
   logic                  st_leaf;
   logic [NVAL_W-1:0]     st_col;
   logic [DEPTH_W-1:0]    wp;
   logic [2:0]            wp_c;

   assign cmd     = req_tuser;
   assign px      = req_tdata[3:0];
   assign py      = req_tdata[7:4];
   assign pz      = req_tdata[11:8];
   assign color   = req_tdata[43:12];
   assign present = req_tdata[44];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign cur_depth = (extent_ff > DEPTH_W'(G)) ? DEPTH_W'(G) : extent_ff;
   assign side      = 7'd1 << cur_depth;
   assign in_cube   = ({3'b000, px} < side) && ({3'b000, py} < side) &&
                      ({3'b000, pz} < side);
   assign wx_pos    = CW'({3'b000, px});
   assign wy_pos    = CW'({3'b000, py});
   assign wz_pos    = CW'({3'b000, pz});
   assign wr_idx    = VOX_AW'(wx_pos) | (VOX_AW'(wy_pos) << G) | (VOX_AW'(wz_pos) << (2 * G));

   // Reduction: group coordinates at level lvl_ff, child number cc_ff.
   assign rk        = depth_ff - lvl_ff - 3'd1;
   assign kmask     = ~({VOX_AW{1'b1}} << rk);
   assign gx        = gi_ff & kmask;
   assign gy        = (gi_ff >> rk) & kmask;
   assign gz        = (gi_ff >> {rk, 1'b0}) & kmask;
   assign cidx      = cc_ff[2:0];
   assign cx        = (gx << 1) | VOX_AW'(cidx[0]);
   assign cy        = (gy << 1) | VOX_AW'(cidx[1]);
   assign cz        = (gz << 1) | VOX_AW'(cidx[2]);
   assign vaddr_red = cx | (cy << G) | (cz << (2 * G));
   assign lidx_red  = cx | (cy << (rk + 3'd1)) | (cz << ({rk, 1'b0} + 4'd2));
   assign lvl_m1    = lvl_ff - 3'd1;
   assign laddr_red = base_ff[lvl_m1[LI_W-1:0]] + LVL_AW'(lidx_red);
   assign waddr_red = base_ff[lvl_ff[LI_W-1:0]] + LVL_AW'(gi_ff);
   assign sz        = VOX_AW'(1) << ({rk, 1'b0} + {1'b0, rk});
   assign last_gi   = sz - VOX_AW'(1);
   assign base_next = base_ff[lvl_ff[LI_W-1:0]] + LVL_AW'(sz);

   assign kc       = cc_ff[2:0] - 3'd1;
   assign kid_leaf = (lvl_ff == '0) ? 1'b1 : lvl_rdata[ENT_W-1];
   assign kid_col  = (lvl_ff == '0) ? NVAL_W'(vox_rdata) : lvl_rdata[ENT_W-2:MASK_W];

   always_comb begin
      if (cc_ff == 4'd1) begin
         uni_n  = kid_leaf;
         mask_n = MASK_W'(kid_leaf);
      end else begin
         uni_n  = uni_ff && kid_leaf && k0_leaf_ff && (kid_col == k0_col_ff);
         mask_n = mask_ff | (MASK_W'(kid_leaf) << kc);
      end
   end

   // Walk: node coordinates come from the child numbers on the stack.
   always_comb begin
      ax = '0;
      ay = '0;
      az = '0;
      for (int j = 0; j < MAXL; j++) begin
         if (DEPTH_W'(j) < wd_ff) begin
            ax = ax | (CW'(stk_c_ff[j][0]) << (wd_ff - DEPTH_W'(j) - 3'd1));
            ay = ay | (CW'(stk_c_ff[j][1]) << (wd_ff - DEPTH_W'(j) - 3'd1));
            az = az | (CW'(stk_c_ff[j][2]) << (wd_ff - DEPTH_W'(j) - 3'd1));
         end
      end
   end

   assign vaddr_walk = VOX_AW'(ax) | (VOX_AW'(ay) << G) | (VOX_AW'(az) << (2 * G));
   assign lidx_walk  = VOX_AW'(ax) | (VOX_AW'(ay) << wd_ff) | (VOX_AW'(az) << {wd_ff, 1'b0});
   assign wl         = depth_ff - wd_ff - 3'd1;
   assign laddr_walk = base_ff[wl[LI_W-1:0]] + LVL_AW'(lidx_walk);
   assign bottom     = (wd_ff == depth_ff);
   assign st_leaf    = bottom || lvl_rdata[ENT_W-1];
   assign st_col     = bottom ? NVAL_W'(vox_rdata) : lvl_rdata[ENT_W-2:MASK_W];
   assign wp         = wd_ff - 3'd1;
   assign wp_c       = stk_c_ff[wp[LI_W-1:0]];

   // Memory ports.
   assign vox_we    = (state_ff == ST_CLEAR) ||
                      (accept && (cmd == CMD_WRITE) && in_cube && (present || zabs_ff));
   assign vox_waddr = (state_ff == ST_CLEAR) ? clr_ff : wr_idx;
   assign vox_wdata = ((state_ff != ST_CLEAR) && present) ? color[COLOR_BITS-1:0] : '0;
   assign vox_raddr = (state_ff == ST_REDUCE) ? vaddr_red : vaddr_walk;

   assign lvl_we    = (state_ff == ST_REDUCE) && (cc_ff == 4'd8);
   assign lvl_waddr = waddr_red;
   assign lvl_wdata = uni_n ? {1'b1, k0_col_ff, {MASK_W{1'b0}}}
                            : {1'b0, {NVAL_W{1'b0}}, mask_n};
   assign lvl_raddr = (state_ff == ST_REDUCE) ? laddr_red : laddr_walk;

   assign node_we    = (state_ff == ST_STORE);
   assign node_wdata = st_leaf ? {1'b1, st_col, {MASK_W{1'b0}}}
                               : {1'b0, NVAL_W'(total_ff), lvl_rdata[MASK_W-1:0]};
   assign node_raddr = NODE_AW'(rdidx_ff);

   vob_ram #(.WIDTH(COLOR_BITS), .DEPTH(VOX_DEPTH)) u_voxel_ram (
      .clock (clock),
      .we    (vox_we),
      .waddr (vox_waddr),
      .wdata (vox_wdata),
      .raddr (vox_raddr),
      .rdata (vox_rdata)
   );

   vob_ram #(.WIDTH(ENT_W), .DEPTH(LVL_DEPTH)) u_level_ram (
      .clock (clock),
      .we    (lvl_we),
      .waddr (lvl_waddr),
      .wdata (lvl_wdata),
      .raddr (lvl_raddr),
      .rdata (lvl_rdata)
   );

   vob_ram #(.WIDTH(ENT_W), .DEPTH(NODE_DEPTH)) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (slot_ff),
      .wdata (node_wdata),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      extent_in    = extent_ff;
      zabs_in      = zabs_ff;
      depth_in     = depth_ff;
      total_in     = total_ff;
      rdidx_in     = rdidx_ff;
      lvl_in       = lvl_ff;
      gi_in        = gi_ff;
      cc_in        = cc_ff;
      k0_leaf_in   = k0_leaf_ff;
      k0_col_in    = k0_col_ff;
      uni_in       = uni_ff;
      mask_in      = mask_ff;
      base_in      = base_ff;
      wd_in        = wd_ff;
      slot_in      = slot_ff;
      stk_c_in     = stk_c_ff;
      stk_f_in     = stk_f_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_we) begin
         if (csr_addr == CSR_EXTENT) begin
            extent_in = csr_wdata;
         end else if (csr_addr == CSR_ZERO_ABSENT) begin
            zabs_in = csr_wdata[0];
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + VOX_AW'(1);
            if (clr_ff == VOX_AW'(VOX_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_BEGIN: begin
                     total_in = '0;
                     rdidx_in = '0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_BUILD: begin
                     depth_in   = cur_depth;
                     rdidx_in   = '0;
                     lvl_in     = '0;
                     gi_in      = '0;
                     cc_in      = '0;
                     base_in[0] = '0;
                     if (cur_depth == '0) begin
                        wd_in    = '0;
                        slot_in  = '0;
                        total_in = CNT_W'(1);
                        state_in = ST_VISIT;
                     end else begin
                        state_in = ST_REDUCE;
                     end
                  end
                  CMD_READ: begin
                     if (rdidx_ff < total_ff) begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = node_rdata[ENT_W-1] ? KIND_LEAF : KIND_PARENT;
            rsp_val_in   = VALUE_W'(node_rdata[ENT_W-2:MASK_W]);
            rsp_mask_in  = node_rdata[ENT_W-1] ? '0 : node_rdata[MASK_W-1:0];
            rsp_last_in  = (rdidx_ff + CNT_W'(1)) == total_ff;
            rdidx_in     = rdidx_ff + CNT_W'(1);
            state_in     = ST_IDLE;
         end
         ST_REDUCE: begin
            if (cc_ff != 4'd0) begin
               if (cc_ff == 4'd1) begin
                  k0_leaf_in = kid_leaf;
                  k0_col_in  = kid_col;
               end
               uni_in  = uni_n;
               mask_in = mask_n;
            end
            if (cc_ff != 4'd8) begin
               cc_in = cc_ff + 4'd1;
            end else begin
               cc_in = '0;
               if (gi_ff == last_gi) begin
                  gi_in = '0;
                  if (lvl_ff + 3'd1 == depth_ff) begin
                     wd_in    = '0;
                     slot_in  = '0;
                     total_in = CNT_W'(1);
                     state_in = ST_VISIT;
                  end else begin
                     lvl_in = lvl_ff + 3'd1;
                     base_in[LI_W'(lvl_ff + 3'd1)] = base_next;
                  end
               end else begin
                  gi_in = gi_ff + VOX_AW'(1);
               end
            end
         end
         ST_VISIT: begin
            state_in = ST_STORE;
         end
         ST_STORE: begin
            if (st_leaf) begin
               state_in = ST_NEXT;
            end else begin
               stk_c_in[wd_ff[LI_W-1:0]] = '0;
               stk_f_in[wd_ff[LI_W-1:0]] = NODE_AW'(total_ff);
               total_in = total_ff + CNT_W'(8);
               slot_in  = NODE_AW'(total_ff);
               wd_in    = wd_ff + 3'd1;
               state_in = ST_VISIT;
            end
         end
         ST_NEXT: begin
            if (wd_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_COUNT;
               rsp_val_in   = VALUE_W'(total_ff);
               rsp_mask_in  = '0;
               rsp_last_in  = 1'b0;
               rdidx_in     = '0;
               state_in     = ST_IDLE;
            end else if (wp_c != 3'd7) begin
               stk_c_in[wp[LI_W-1:0]] = wp_c + 3'd1;
               slot_in  = stk_f_ff[wp[LI_W-1:0]] + NODE_AW'(wp_c) + NODE_AW'(1);
               state_in = ST_VISIT;
            end else begin
               wd_in = wp;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         extent_ff    <= EXTENT_RESET;
         zabs_ff      <= 1'b1;
         total_ff     <= '0;
         rdidx_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         lvl_ff       <= '0;
         wd_ff        <= '0;
         cc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         extent_ff    <= extent_in;
         zabs_ff      <= zabs_in;
         total_ff     <= total_in;
         rdidx_ff     <= rdidx_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
         lvl_ff       <= lvl_in;
         wd_ff        <= wd_in;
         cc_ff        <= cc_in;
      end
   end

   always_ff @(posedge clock) begin
      gi_ff       <= gi_in;
      k0_leaf_ff  <= k0_leaf_in;
      k0_col_ff   <= k0_col_in;
      uni_ff      <= uni_in;
      mask_ff     <= mask_in;
      base_ff     <= base_in;
      slot_ff     <= slot_in;
      stk_c_ff    <= stk_c_in;
      stk_f_ff    <= stk_f_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_mask_ff, rsp_val_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE))
      else $error("request taken outside the idle state");

   assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(NODE_DEPTH))
      else $error("node count beyond the node store");

   assert property (@(posedge clock) disable iff (reset)
      rdidx_ff <= total_ff)
      else $error("read index passed the node count");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_VISIT) || (state_ff == ST_STORE) || (state_ff == ST_NEXT))
      |-> (wd_ff <= depth_ff))
      else $error("walk deeper than the tree");
`endif

endmodule

// ===== sv/vob_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
